/* design/pogs_pkg.sv */
package pogs_pkg;

    localparam int DIV_STAGES = 16;
    localparam int DIV_STEPS  = 4;

    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

    localparam logic [1:0]  CFG_DIMS = 2'd0;
    localparam logic [1:0]  CFG_OUTP = 2'd1;
    localparam logic [1:0]  DIMS_RST = 2'd3;
    localparam logic [30:0] OUTP_RST = 31'd65536;

    typedef struct packed {
        logic [31:0] mom_x;
        logic [31:0] mom_y;
        logic [31:0] mom_z;
        logic [30:0] rho;
        logic [31:0] energy;
    } t_pass;

    typedef struct packed {
        t_pass        pass;
        logic [63:0]  msq;
        logic [63:0]  nsq;
        logic [130:0] lhs;
        logic         dneg;
        logic         bad;
    } t_front;

endpackage

/* design/pogs_front.sv */
module pogs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_mom_x,
    input  logic [31:0]           i_mom_y,
    input  logic [31:0]           i_mom_z,
    input  logic [30:0]           i_density,
    input  logic [31:0]           i_energy,
    input  logic [31:0]           i_normal_x,
    input  logic [31:0]           i_normal_y,
    input  logic [31:0]           i_normal_z,
    input  logic                  i_face_side,
    input  logic [1:0]            i_dims,
    output logic                  o_valid,
    output pogs_pkg::t_front      o_data
);
    import pogs_pkg::*;

    logic               use_y, use_z;
    logic signed [63:0] c_mm [3];
    logic signed [63:0] c_nn [3];
    logic signed [63:0] c_mn [3];

    logic [5:0]         r_vld;
    t_pass              r1_pass, r2_pass, r3_pass, r4_pass, r5_pass;
    logic               r1_side, r2_side;
    logic signed [63:0] r1_mm [3];
    logic signed [63:0] r1_nn [3];
    logic signed [63:0] r1_mn [3];
    logic [63:0]        r2_msq, r3_msq, r4_msq, r5_msq;
    logic [63:0]        r2_nsq, r3_nsq, r4_nsq, r5_nsq;
    logic signed [65:0] r2_dot;
    logic               r2_bad, r3_bad, r4_bad, r5_bad;
    logic [63:0]        r3_dmag;
    logic               r3_dneg, r4_dneg, r5_dneg;
    logic [63:0]        r4_p00, r4_p01, r4_p11;
    logic [127:0]       r5_sq;
    t_front             r6_data;

    logic [63:0]        n_msq, n_nsq;
    logic signed [65:0] n_dot;
    logic [65:0]        n_dabs;

    assign use_y = (i_dims == 2'd2) || (i_dims == 2'd3);
    assign use_z = (i_dims == 2'd3);

    assign c_mm[0] = $signed(i_mom_x) * $signed(i_mom_x);
    assign c_nn[0] = $signed(i_normal_x) * $signed(i_normal_x);
    assign c_mn[0] = $signed(i_mom_x) * $signed(i_normal_x);
    assign c_mm[1] = use_y ? $signed(i_mom_y) * $signed(i_mom_y) : 64'sd0;
    assign c_nn[1] = use_y ? $signed(i_normal_y) * $signed(i_normal_y) : 64'sd0;
    assign c_mn[1] = use_y ? $signed(i_mom_y) * $signed(i_normal_y) : 64'sd0;
    assign c_mm[2] = use_z ? $signed(i_mom_z) * $signed(i_mom_z) : 64'sd0;
    assign c_nn[2] = use_z ? $signed(i_normal_z) * $signed(i_normal_z) : 64'sd0;
    assign c_mn[2] = use_z ? $signed(i_mom_z) * $signed(i_normal_z) : 64'sd0;

    assign n_msq  = 64'(r1_mm[0]) + 64'(r1_mm[1]) + 64'(r1_mm[2]);
    assign n_nsq  = 64'(r1_nn[0]) + 64'(r1_nn[1]) + 64'(r1_nn[2]);
    assign n_dot  = 66'(r1_mn[0]) + 66'(r1_mn[1]) + 66'(r1_mn[2]);
    assign n_dabs = r2_dot[65] ? 66'(-r2_dot) : 66'(r2_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass <= '{i_mom_x, i_mom_y, i_mom_z, i_density, i_energy};
            r1_side <= i_face_side;
            r1_mm   <= c_mm;
            r1_nn   <= c_nn;
            r1_mn   <= c_mn;

            r2_pass <= r1_pass;
            r2_side <= r1_side;
            r2_msq  <= n_msq;
            r2_nsq  <= n_nsq;
            r2_dot  <= n_dot;
            r2_bad  <= (r1_pass.rho == '0) || (n_nsq == '0);

            r3_pass <= r2_pass;
            r3_msq  <= r2_msq;
            r3_nsq  <= r2_nsq;
            r3_bad  <= r2_bad;
            r3_dmag <= n_dabs[63:0];
            r3_dneg <= (r2_dot != '0) && (r2_dot[65] ^ !r2_side);

            r4_pass <= r3_pass;
            r4_msq  <= r3_msq;
            r4_nsq  <= r3_nsq;
            r4_bad  <= r3_bad;
            r4_dneg <= r3_dneg;
            r4_p00  <= r3_dmag[31:0] * r3_dmag[31:0];
            r4_p01  <= r3_dmag[31:0] * r3_dmag[63:32];
            r4_p11  <= r3_dmag[63:32] * r3_dmag[63:32];

            r5_pass <= r4_pass;
            r5_msq  <= r4_msq;
            r5_nsq  <= r4_nsq;
            r5_bad  <= r4_bad;
            r5_dneg <= r4_dneg;
            r5_sq   <= {64'd0, r4_p00} + ({64'd0, r4_p01} << 33) + {r4_p11, 64'd0};

            r6_data.pass <= r5_pass;
            r6_data.msq  <= r5_msq;
            r6_data.nsq  <= r5_nsq;
            r6_data.bad  <= r5_bad;
            r6_data.dneg <= r5_dneg;
            r6_data.lhs  <= {3'd0, r5_sq} + {1'b0, r5_sq, 2'd0};
        end
    end

    assign o_valid = r_vld[5];
    assign o_data  = r6_data;

endmodule

/* design/pogs_div.sv */
module pogs_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  pogs_pkg::t_front      i_data,
    output logic                  o_valid,
    output pogs_pkg::t_front      o_data,
    output logic [63:0]           o_kin
);
    import pogs_pkg::*;

    t_front      r_dat [DIV_STAGES];
    logic [31:0] r_rem [DIV_STAGES];
    logic [63:0] r_qd  [DIV_STAGES];
    logic        r_vld [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_front      src_dat;
        logic [31:0] src_rem;
        logic [63:0] src_qd;
        logic        src_vld;
        logic [31:0] n_rem;
        logic [63:0] n_qd;

        if (s == 0) begin : g_head
            assign src_dat = i_data;
            assign src_rem = '0;
            assign src_qd  = i_data.msq;
            assign src_vld = i_valid;
        end else begin : g_body
            assign src_dat = r_dat[s-1];
            assign src_rem = r_rem[s-1];
            assign src_qd  = r_qd[s-1];
            assign src_vld = r_vld[s-1];
        end

        always_comb begin
            logic [32:0] t;
            logic [32:0] dvs;
            dvs   = {1'b0, src_dat.pass.rho, 1'b0};
            n_rem = src_rem;
            n_qd  = src_qd;
            for (int k = 0; k < DIV_STEPS; k++) begin
                t    = {n_rem, n_qd[63]};
                n_qd = {n_qd[62:0], 1'b0};
                if (t >= dvs) begin
                    t       = t - dvs;
                    n_qd[0] = 1'b1;
                end
                n_rem = t[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dat[s] <= src_dat;
                r_rem[s] <= n_rem;
                r_qd[s]  <= n_qd;
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_data  = r_dat[DIV_STAGES-1];
    assign o_kin   = r_qd[DIV_STAGES-1];

endmodule

/* design/pogs_back.sv */
module pogs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  pogs_pkg::t_front      i_data,
    input  logic [63:0]           i_kin,
    input  logic [30:0]           i_outp,
    output logic                  o_valid,
    output logic [31:0]           o_ghost_mom_x,
    output logic [31:0]           o_ghost_mom_y,
    output logic [31:0]           o_ghost_mom_z,
    output logic [30:0]           o_ghost_density,
    output logic [31:0]           o_ghost_energy,
    output logic                  o_pressure_imposed,
    output logic                  o_bad_input
);
    import pogs_pkg::*;

    logic         n_dpos;
    logic [33:0]  n_op5;
    logic [64:0]  n_gsum;
    logic [63:0]  n_x5;
    logic         n_sub;

    logic [6:0]   r_vld;
    t_pass        r1_pass, r2_pass, r3_pass, r4_pass, r5_pass, r6_pass, r7_pass;
    logic [130:0] r1_lhs, r2_lhs, r3_lhs, r4_lhs, r5_lhs;
    logic [63:0]  r1_nsq, r2_nsq, r3_nsq;
    logic         r1_dneg, r2_dneg, r3_dneg, r4_dneg, r5_dneg;
    logic         r1_bad, r2_bad, r3_bad, r4_bad, r5_bad;
    logic [31:0]  r1_gsat, r2_gsat, r3_gsat, r4_gsat, r5_gsat;
    logic [31:0]  r1_x;
    logic [29:0]  r2_pres;
    logic [60:0]  r3_pr;
    logic [63:0]  r4_q00, r4_q01;
    logic [60:0]  r4_q10, r4_q11;
    logic [124:0] r5_prod;
    logic [127:0] r6_rhs;
    logic [130:0] r6_lhs;
    logic         r6_dneg, r6_bad;
    logic [31:0]  r6_gsat;
    logic [31:0]  r7_energy;
    logic         r7_imp, r7_bad;

    assign n_dpos = !i_data.pass.energy[31]
                    && (i_kin < {33'd0, i_data.pass.energy[30:0]});
    assign n_op5  = {3'd0, i_outp} + {1'b0, i_outp, 2'd0};
    assign n_gsum = {1'b0, i_kin} + {32'd0, n_op5[33:1]};
    assign n_x5   = r1_x * RECIP5;
    assign n_sub  = r6_dneg || (r6_lhs < {3'd0, r6_rhs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass <= i_data.pass;
            r1_lhs  <= i_data.lhs;
            r1_nsq  <= i_data.nsq;
            r1_dneg <= i_data.dneg;
            r1_bad  <= i_data.bad;
            r1_x    <= n_dpos ? {i_data.pass.energy[30:0] - i_kin[30:0], 1'b0} : '0;
            r1_gsat <= (n_gsum[64:31] != '0) ? 32'h7FFF_FFFF : {1'b0, n_gsum[30:0]};

            r2_pass <= r1_pass;
            r2_lhs  <= r1_lhs;
            r2_nsq  <= r1_nsq;
            r2_dneg <= r1_dneg;
            r2_bad  <= r1_bad;
            r2_gsat <= r1_gsat;
            r2_pres <= n_x5[63:34];

            r3_pass <= r2_pass;
            r3_lhs  <= r2_lhs;
            r3_nsq  <= r2_nsq;
            r3_dneg <= r2_dneg;
            r3_bad  <= r2_bad;
            r3_gsat <= r2_gsat;
            r3_pr   <= {31'd0, r2_pres} * {30'd0, r2_pass.rho};

            r4_pass <= r3_pass;
            r4_lhs  <= r3_lhs;
            r4_dneg <= r3_dneg;
            r4_bad  <= r3_bad;
            r4_gsat <= r3_gsat;
            r4_q00  <= r3_pr[31:0] * r3_nsq[31:0];
            r4_q01  <= r3_pr[31:0] * r3_nsq[63:32];
            r4_q10  <= {32'd0, r3_pr[60:32]} * {29'd0, r3_nsq[31:0]};
            r4_q11  <= {32'd0, r3_pr[60:32]} * {29'd0, r3_nsq[63:32]};

            r5_pass <= r4_pass;
            r5_lhs  <= r4_lhs;
            r5_dneg <= r4_dneg;
            r5_bad  <= r4_bad;
            r5_gsat <= r4_gsat;
            r5_prod <= {61'd0, r4_q00} + ({61'd0, r4_q01} << 32)
                       + ({64'd0, r4_q10} << 32) + {r4_q11, 64'd0};

            r6_pass <= r5_pass;
            r6_lhs  <= r5_lhs;
            r6_dneg <= r5_dneg;
            r6_bad  <= r5_bad;
            r6_gsat <= r5_gsat;
            r6_rhs  <= {r5_prod, 3'd0} - {3'd0, r5_prod};

            r7_pass   <= r6_pass;
            r7_bad    <= r6_bad;
            r7_imp    <= !r6_bad && n_sub;
            r7_energy <= (!r6_bad && n_sub) ? r6_gsat : r6_pass.energy;
        end
    end

    assign o_valid            = r_vld[6];
    assign o_ghost_mom_x      = r7_pass.mom_x;
    assign o_ghost_mom_y      = r7_pass.mom_y;
    assign o_ghost_mom_z      = r7_pass.mom_z;
    assign o_ghost_density    = r7_pass.rho;
    assign o_ghost_energy     = r7_energy;
    assign o_pressure_imposed = r7_imp;
    assign o_bad_input        = r7_bad;

endmodule

/* design/pressure_outflow_ghost_state_unit.sv */
// Subsonic pressure-outflow ghost state: one face quadrature point per transaction, one
// result per transaction. The block takes a new point every cycle while the result side
// keeps taking results; a stalled result holds the whole pipeline. The 16-stage divider
// forms the kinetic energy (four quotient bits per stage) and is followed by the pressure
// and sound-speed compare stages.
// Configuration is written through its own channel, which is always ready.
module pressure_outflow_ghost_state_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_mom_x,
    input  logic [31:0] i_mom_y,
    input  logic [31:0] i_mom_z,
    input  logic [30:0] i_density,
    input  logic [31:0] i_energy,
    input  logic [31:0] i_normal_x,
    input  logic [31:0] i_normal_y,
    input  logic [31:0] i_normal_z,
    input  logic        i_face_side,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_ghost_mom_x,
    output logic [31:0] o_ghost_mom_y,
    output logic [31:0] o_ghost_mom_z,
    output logic [30:0] o_ghost_density,
    output logic [31:0] o_ghost_energy,
    output logic        o_pressure_imposed,
    output logic        o_bad_input,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import pogs_pkg::*;

    logic [1:0]  r_dims;
    logic [30:0] r_outp;
    logic        en;
    logic        f_valid, d_valid;
    t_front      f_data, d_data;
    logic [63:0] d_kin;

    assign o_cfg_ready = 1'b1;
    assign en          = !o_valid || i_ready;
    assign o_ready     = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RST;
            r_outp <= OUTP_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DIMS) begin
                r_dims <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_OUTP) begin
                r_outp <= i_cfg_data;
            end
        end
    end

    pogs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_mom_x     (i_mom_x),
        .i_mom_y     (i_mom_y),
        .i_mom_z     (i_mom_z),
        .i_density   (i_density),
        .i_energy    (i_energy),
        .i_normal_x  (i_normal_x),
        .i_normal_y  (i_normal_y),
        .i_normal_z  (i_normal_z),
        .i_face_side (i_face_side),
        .i_dims      (r_dims),
        .o_valid     (f_valid),
        .o_data      (f_data)
    );

    pogs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_valid (d_valid),
        .o_data  (d_data),
        .o_kin   (d_kin)
    );

    pogs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (en),
        .i_valid            (d_valid),
        .i_data             (d_data),
        .i_kin              (d_kin),
        .i_outp             (r_outp),
        .o_valid            (o_valid),
        .o_ghost_mom_x      (o_ghost_mom_x),
        .o_ghost_mom_y      (o_ghost_mom_y),
        .o_ghost_mom_z      (o_ghost_mom_z),
        .o_ghost_density    (o_ghost_density),
        .o_ghost_energy     (o_ghost_energy),
        .o_pressure_imposed (o_pressure_imposed),
        .o_bad_input        (o_bad_input)
    );

endmodule

/* design/pogs_checker.sv */
module pogs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [30:0] o_ghost_density,
    input logic [31:0] o_ghost_energy,
    input logic        o_pressure_imposed,
    input logic        o_bad_input
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ghost_energy))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_bad_input && o_pressure_imposed))
        else $error("bad transaction marked as pressure imposed");

    a_zero_rho: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ghost_density == '0) |-> o_bad_input)
        else $error("zero density not flagged");

    a_imp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_imposed |-> !o_ghost_energy[31])
        else $error("imposed energy negative");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind pressure_outflow_ghost_state_unit pogs_checker u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_ghost_density    (o_ghost_density),
    .o_ghost_energy     (o_ghost_energy),
    .o_pressure_imposed (o_pressure_imposed),
    .o_bad_input        (o_bad_input)
);
